FILE: rtl/fractal_value_noise_macros.svh
// Assertion helpers for the noise block; both sample on i_clk and are off in reset.
`ifndef FRACTAL_VALUE_NOISE_MACROS_SVH
`define FRACTAL_VALUE_NOISE_MACROS_SVH

// Same-cycle implication.
`define FVN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FVN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fvn_pkg.sv
package fvn_pkg;

    localparam int MAX_OCTAVES_DEF = 16;
    localparam int FADE_BITS_DEF   = 10;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef logic [31:0] t_word;
    typedef logic [3:0]  t_cfg_idx;
    typedef logic [16:0] t_q16;

    localparam t_cfg_idx CFG_HASH_MUL_A  = 4'd0;
    localparam t_cfg_idx CFG_HASH_ADD_B  = 4'd1;
    localparam t_cfg_idx CFG_HASH_ADD_C  = 4'd2;
    localparam t_cfg_idx CFG_STRIDE_Y    = 4'd3;
    localparam t_cfg_idx CFG_STRIDE_Z    = 4'd4;
    localparam t_cfg_idx CFG_PERSISTENCE = 4'd5;
    localparam t_cfg_idx CFG_OCTAVES     = 4'd6;
    localparam t_cfg_idx CFG_INTERP      = 4'd7;

    localparam t_word       RST_HASH_MUL_A  = 32'd15731;
    localparam t_word       RST_HASH_ADD_B  = 32'd789221;
    localparam t_word       RST_HASH_ADD_C  = 32'd1376312589;
    localparam t_word       RST_STRIDE_Y    = 32'd57;
    localparam t_word       RST_STRIDE_Z    = 32'd107;
    localparam t_q16        RST_PERSISTENCE = 17'd32768;
    localparam logic [4:0]  RST_OCTAVES     = 5'd4;
    localparam logic        RST_INTERP      = 1'b1;

    localparam t_q16        AMP_ONE         = 17'h10000;
    localparam logic        INTERP_LINEAR   = 1'b0;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 41;
    localparam int TOT_W  = 37;

endpackage

FILE: rtl/fvn_if.sv
interface fvn_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;

    modport source (output valid, output mode, output coord_x, output coord_y,
                    output coord_z, input ready);
    modport sink   (input valid, input mode, input coord_x, input coord_y,
                    input coord_z, output ready);
endinterface

interface fvn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

FILE: rtl/fractal_value_noise.sv
// Channel   Dir  Payload                               Accepted when
// i_in      in   mode, coord_x, coord_y, coord_z       valid & ready
// o_out     out  noise_value                           valid & ready
// i_cfg_*   in   index, data                           i_cfg_we
//
// One item per run; ready only while idle. A zero octave count goes straight to the finish.
// Most of each octave's run is the hash, done for each of the 3^d neighbours of the 2^d corners,
// not shared between corners; it squares the mixed index, multiplies by the hash factor, then by
// the saved index plus the first addend, all on the one shared 34x34 multiplier.
// Reset (synchronous, active low) clears the sequencer and loads register defaults.
// The result waits in an output register; a stalled output holds the next finish only.
`include "fractal_value_noise_macros.svh"

module fractal_value_noise #(
    parameter int MAX_OCTAVES     = fvn_pkg::MAX_OCTAVES_DEF,
    parameter int FADE_TABLE_BITS = fvn_pkg::FADE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fvn_in_if.sink            i_in,
    fvn_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  fvn_pkg::t_cfg_idx i_cfg_idx,
    input  fvn_pkg::t_word    i_cfg_data
);
    import fvn_pkg::*;

    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRE, ST_BASE0, ST_BASE1, ST_BASE2, ST_FADE,
        ST_HASH0, ST_HASH1, ST_HASH2, ST_HASH3, ST_BLEND0, ST_BLEND1,
        ST_ACC0, ST_ACC1, ST_ACC2, ST_DONE
    } t_state;

    t_state r_state;

    // configuration
    t_word      r_ha, r_hb, r_hc, r_sy, r_sz;
    t_q16       r_pers;
    logic [4:0] r_oct;
    logic       r_kind;

    // item working set
    logic [1:0]        r_dim;
    logic [OCT_W-1:0]  r_noct, r_k;
    logic [47:0]       r_cx, r_cy, r_cz;
    t_word             r_szy, r_base, r_m;
    t_q16              r_w [3];
    logic [1:0]        r_fcnt;
    logic [2:0]        r_corner;
    logic [1:0]        r_dx, r_dy, r_dz;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0] r_q [8];
    logic [3:0]        r_qn;
    logic [1:0]        r_ax, r_j;
    t_q16              r_amp;
    logic signed [TOT_W-1:0] r_total;
    logic              r_ovalid;
    logic signed [31:0] r_out;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    t_word                    prod_lo;

    logic [FADE_TABLE_BITS-1:0] rom_addr;
    t_q16                       rom_q;

    logic [15:0] frac_cur, frac_prev;
    logic [1:0]  sum_x, sum_y, sum_z;
    t_word       hash_n, hash_m, hash_h;
    logic signed [31:0] lat_v;
    logic [1:0]  nz, wsh;
    logic signed [ACC_W-1:0] n_acc, acc_term, smooth;
    logic        nb_last, corner_last, j_last, out_free;
    logic signed [33:0] bl_a, bl_diff, bl_res;
    t_q16        pers_sat;
    logic [OCT_W-1:0] oct_sat;
    logic [1:0]  dim_in;

    fvn_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (mul_a),
        .i_op_b (mul_b),
        .o_prod (prod)
    );

    fvn_fade_rom #(.TABLE_BITS(FADE_TABLE_BITS)) u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_q)
    );

    // offset code 0..3 stands for -1..2 lattice steps
    function automatic t_word stride_term(logic [1:0] code, t_word s);
        case (code)
            2'd0:    stride_term = -s;
            2'd1:    stride_term = '0;
            2'd2:    stride_term = s;
            default: stride_term = {s[30:0], 1'b0};
        endcase
    endfunction

    assign prod_lo  = prod[31:0];
    assign pers_sat = (r_pers > AMP_ONE) ? AMP_ONE : r_pers;
    assign oct_sat  = ({27'd0, r_oct} > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES) : OCT_W'(r_oct);
    assign dim_in   = (i_in.mode == 2'd0) ? 2'd1 : (i_in.mode == 2'd1) ? 2'd2 : 2'd3;

    always_comb begin
        case (r_fcnt)
            2'd0:    frac_cur = r_cx[15:0];
            2'd1:    frac_cur = r_cy[15:0];
            default: frac_cur = r_cz[15:0];
        endcase
        case (r_fcnt)
            2'd1:    frac_prev = r_cx[15:0];
            2'd2:    frac_prev = r_cy[15:0];
            default: frac_prev = r_cz[15:0];
        endcase
    end
    assign rom_addr = frac_cur[15 -: FADE_TABLE_BITS];

    // lattice point of the current neighbour: the fold is linear in the offsets
    assign sum_x  = {1'b0, r_corner[0]} + r_dx;
    assign sum_y  = {1'b0, r_corner[1]} + r_dy;
    assign sum_z  = {1'b0, r_corner[2]} + r_dz;
    assign hash_n = r_base + stride_term(sum_x, 32'd1) + stride_term(sum_y, r_sy)
                  + stride_term(sum_z, r_szy);
    assign hash_m = {hash_n[18:0], 13'd0} ^ hash_n;
    assign hash_h = prod_lo + r_hc;
    assign lat_v  = $signed(32'h4000_0000 - {1'b0, hash_h[30:0]});

    assign nz       = 2'((r_dx != 2'd1)) + 2'((r_dy != 2'd1)) + 2'((r_dz != 2'd1));
    assign wsh      = r_dim - nz;
    assign acc_term = $signed({{(ACC_W-32){lat_v[31]}}, lat_v}) <<< wsh;
    assign n_acc    = r_acc + acc_term;
    assign smooth   = n_acc >>> {r_dim, 1'b0};
    assign nb_last  = (r_dx == 2'd2) && ((r_dim < 2'd2) || (r_dy == 2'd2))
                   && ((r_dim < 2'd3) || (r_dz == 2'd2));
    assign corner_last = (({1'b0, r_corner} + 4'd1) == (4'd1 << r_dim));

    assign bl_a    = {{2{r_q[0][31]}}, r_q[0]};
    assign bl_diff = {{2{r_q[1][31]}}, r_q[1]} - bl_a;
    assign bl_res  = bl_a + prod[49:16];
    assign j_last  = (({1'b0, r_j} + 3'd1) == (3'd1 << (r_dim - 2'd1 - r_ax)));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_PRE: begin
                mul_a = {2'b0, r_sy};
                mul_b = {2'b0, r_sz};
            end
            ST_BASE0: begin
                mul_a = {2'b0, r_cy[47:16]};
                mul_b = {2'b0, r_sy};
            end
            ST_BASE1: begin
                mul_a = {2'b0, r_cz[47:16]};
                mul_b = {2'b0, r_szy};
            end
            ST_HASH0: begin
                mul_a = {2'b0, hash_m};
                mul_b = {2'b0, hash_m};
            end
            ST_HASH1: begin
                mul_a = {2'b0, prod_lo};
                mul_b = {2'b0, r_ha};
            end
            ST_HASH2: begin
                mul_a = {2'b0, r_m};
                mul_b = {2'b0, prod_lo + r_hb};
            end
            ST_BLEND0: begin
                mul_a = bl_diff;
                mul_b = {17'd0, r_w[r_ax]};
            end
            ST_ACC0: begin
                mul_a = {{2{r_q[0][31]}}, r_q[0]};
                mul_b = {17'd0, r_amp};
            end
            ST_ACC1: begin
                mul_a = {17'd0, r_amp};
                mul_b = {17'd0, pers_sat};
            end
            default: ;
        endcase
    end

    assign out_free    = !r_ovalid || o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.noise_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_ha     <= RST_HASH_MUL_A;
            r_hb     <= RST_HASH_ADD_B;
            r_hc     <= RST_HASH_ADD_C;
            r_sy     <= RST_STRIDE_Y;
            r_sz     <= RST_STRIDE_Z;
            r_pers   <= RST_PERSISTENCE;
            r_oct    <= RST_OCTAVES;
            r_kind   <= RST_INTERP;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HASH_MUL_A:  r_ha   <= i_cfg_data;
                    CFG_HASH_ADD_B:  r_hb   <= i_cfg_data;
                    CFG_HASH_ADD_C:  r_hc   <= i_cfg_data;
                    CFG_STRIDE_Y:    r_sy   <= i_cfg_data;
                    CFG_STRIDE_Z:    r_sz   <= i_cfg_data;
                    CFG_PERSISTENCE: r_pers <= i_cfg_data[16:0];
                    CFG_OCTAVES:     r_oct  <= i_cfg_data[4:0];
                    CFG_INTERP:      r_kind <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // in the done state the finish below decides the valid flag
            if (r_ovalid && o_out.ready && (r_state != ST_DONE)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_dim   <= dim_in;
                        r_noct  <= oct_sat;
                        r_k     <= '0;
                        r_amp   <= AMP_ONE;
                        r_total <= '0;
                        r_cx    <= {{16{i_in.coord_x[31]}}, i_in.coord_x};
                        // unused axes drop out of the fold
                        r_cy    <= (dim_in >= 2'd2) ? {{16{i_in.coord_y[31]}}, i_in.coord_y}
                                                    : 48'd0;
                        r_cz    <= (dim_in == 2'd3) ? {{16{i_in.coord_z[31]}}, i_in.coord_z}
                                                    : 48'd0;
                        r_state <= (oct_sat == '0) ? ST_DONE : ST_PRE;
                    end
                end
                ST_PRE: begin
                    r_state <= ST_BASE0;
                end
                ST_BASE0: begin
                    r_szy   <= prod_lo;
                    r_state <= ST_BASE1;
                end
                ST_BASE1: begin
                    r_base  <= r_cx[47:16] + prod_lo;
                    r_state <= ST_BASE2;
                end
                ST_BASE2: begin
                    r_base  <= r_base + prod_lo;
                    r_fcnt  <= 2'd0;
                    r_state <= ST_FADE;
                end
                ST_FADE: begin
                    if (r_fcnt != 2'd0) begin
                        r_w[r_fcnt - 2'd1] <= (r_kind == INTERP_LINEAR) ? {1'b0, frac_prev}
                                                                         : rom_q;
                    end
                    r_fcnt <= r_fcnt + 2'd1;
                    if (r_fcnt == 2'd3) begin
                        r_corner <= 3'd0;
                        r_dx     <= 2'd0;
                        r_dy     <= (r_dim >= 2'd2) ? 2'd0 : 2'd1;
                        r_dz     <= (r_dim == 2'd3) ? 2'd0 : 2'd1;
                        r_acc    <= '0;
                        r_qn     <= 4'd0;
                        r_state  <= ST_HASH0;
                    end
                end
                ST_HASH0: begin
                    r_m     <= hash_m;
                    r_state <= ST_HASH1;
                end
                ST_HASH1: begin
                    r_state <= ST_HASH2;
                end
                ST_HASH2: begin
                    r_state <= ST_HASH3;
                end
                ST_HASH3: begin
                    r_state <= ST_HASH0;
                    if (nb_last) begin
                        r_q[r_qn[2:0]] <= smooth[31:0];
                        r_qn  <= r_qn + 4'd1;
                        r_acc <= '0;
                        r_dx  <= 2'd0;
                        r_dy  <= (r_dim >= 2'd2) ? 2'd0 : 2'd1;
                        r_dz  <= (r_dim == 2'd3) ? 2'd0 : 2'd1;
                        if (corner_last) begin
                            r_ax    <= 2'd0;
                            r_j     <= 2'd0;
                            r_state <= ST_BLEND0;
                        end else begin
                            r_corner <= r_corner + 3'd1;
                        end
                    end else begin
                        r_acc <= n_acc;
                        if (r_dx != 2'd2) begin
                            r_dx <= r_dx + 2'd1;
                        end else begin
                            r_dx <= 2'd0;
                            if (r_dim >= 2'd2 && r_dy != 2'd2) begin
                                r_dy <= r_dy + 2'd1;
                            end else begin
                                r_dy <= (r_dim >= 2'd2) ? 2'd0 : 2'd1;
                                r_dz <= r_dz + 2'd1;
                            end
                        end
                    end
                end
                ST_BLEND0: begin
                    r_state <= ST_BLEND1;
                end
                ST_BLEND1: begin
                    // pop the pair at the head, append the blend at the tail
                    for (int i = 0; i < 6; i++) begin
                        r_q[i] <= (3'(i) == 3'(r_qn - 4'd2)) ? bl_res[31:0] : r_q[i + 2];
                    end
                    if (r_qn == 4'd8) begin
                        r_q[6] <= bl_res[31:0];
                    end
                    r_qn <= r_qn - 4'd1;
                    if (j_last) begin
                        r_j  <= 2'd0;
                        r_ax <= r_ax + 2'd1;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                    r_state <= (r_qn == 4'd2) ? ST_ACC0 : ST_BLEND0;
                end
                ST_ACC0: begin
                    r_state <= ST_ACC1;
                end
                ST_ACC1: begin
                    r_total <= r_total + prod[TOT_W+15:16];
                    r_state <= ST_ACC2;
                end
                ST_ACC2: begin
                    r_amp <= prod[32:16];
                    r_cx  <= {r_cx[46:0], 1'b0};
                    r_cy  <= {r_cy[46:0], 1'b0};
                    r_cz  <= {r_cz[46:0], 1'b0};
                    r_k   <= r_k + 1'b1;
                    r_state <= ((r_k + 1'b1) == r_noct) ? ST_DONE : ST_PRE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        // total stays below 2^36, so the shifted sum always fits
                        r_out    <= {r_total[TOT_W-1], r_total[TOT_W-1:6]};
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `FVN_ASSERT_NEXT(a_one_item, i_in.valid && i_in.ready, !i_in.ready, "second item taken while busy")
    `FVN_ASSERT_NOW(a_amp_range, r_state == ST_ACC0, r_amp <= AMP_ONE, "amplitude above one")
    `FVN_ASSERT_NOW(a_blend_pair, r_state == ST_BLEND0, r_qn >= 4'd2, "blend without a pair")
    `FVN_ASSERT_NOW(a_corner_range, r_state == ST_HASH0, ({1'b0, r_corner} < (4'd1 << r_dim)), "corner out of range")
endmodule

FILE: rtl/fvn_mul.sv
module fvn_mul (
    input  logic                                   i_clk,
    input  logic signed [fvn_pkg::MUL_W-1:0]       i_op_a,
    input  logic signed [fvn_pkg::MUL_W-1:0]       i_op_b,
    output logic signed [fvn_pkg::PROD_W-1:0]      o_prod
);
    import fvn_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;
endmodule

FILE: rtl/fvn_fade_rom.sv
module fvn_fade_rom #(
    parameter int TABLE_BITS = fvn_pkg::FADE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic [TABLE_BITS-1:0] i_addr,
    output fvn_pkg::t_q16         o_data
);
    import fvn_pkg::*;

    localparam int DEPTH = 1 << TABLE_BITS;

    typedef t_q16 t_rom [DEPTH];

    // sin^2 of a quarter turn, Taylor series through x^13 in Q2.30
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] q;
        for (int i = 0; i < DEPTH; i++) begin
            x    = (PI_HALF_Q30 * 64'(i)) >> TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            pos  = x;
            neg  = 64'd0;
            for (int k = 1; k <= 6; k++) begin
                q = (term * x2) >> 30;
                // divide by (2k)(2k+1)
                case (k)
                    1:       term = q / 64'd6;
                    2:       term = q / 64'd20;
                    3:       term = q / 64'd42;
                    4:       term = q / 64'd72;
                    5:       term = q / 64'd110;
                    default: term = q / 64'd156;
                endcase
                if ((k & 1) == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            s = (pos > neg) ? pos - neg : 64'd0;
            if (s > ONE_Q30) begin
                s = ONE_Q30;
            end
            rom[i] = 17'((s * s + (64'd1 << 43)) >> 44);
        end
        return rom;
    endfunction

    localparam t_rom FADE_ROM = build_rom();

    t_q16 r_data;

    always_ff @(posedge i_clk) begin
        r_data <= FADE_ROM[i_addr];
    end

    assign o_data = r_data;
endmodule
